>>> sv/vti_pkg.sv
// Shared types, constants and helpers for the video timer interrupt unit.
// No dependencies; every other file in sv/ refers to this package by scoped name.
`default_nettype none

package vti_pkg;

  // Scanline timing
  localparam int unsigned LINE_CYCLES    = 456;
  localparam int unsigned LAST_LINE      = 153;
  localparam int unsigned VBLANK_LINE    = 144;
  localparam int unsigned HBLANK_START   = 252;
  localparam int unsigned TRANSFER_START = 80;
  localparam int unsigned DIV_CYCLES     = 256;

  // Field widths
  localparam int unsigned CYC_W      = 5;
  localparam int unsigned LINE_CNT_W = 9;
  localparam int unsigned DIV_CNT_W  = 9;
  localparam int unsigned TMR_CNT_W  = 11;
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned IRQ_W      = 5;
  localparam int unsigned VEC_W      = 7;
  localparam int unsigned TCTRL_W    = 3;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 8;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_LINE_COMPARE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COMPARE_IRQ_EN = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMER_CONTROL  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMER_MODULO   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_IRQ_ENABLE     = 3'd4;

  // LCD mode codes
  localparam logic [1:0] MODE_HBLANK   = 2'd0;
  localparam logic [1:0] MODE_VBLANK   = 2'd1;
  localparam logic [1:0] MODE_SEARCH   = 2'd2;
  localparam logic [1:0] MODE_TRANSFER = 2'd3;

  // Interrupt source bit positions
  localparam int unsigned IRQ_VBLANK  = 0;
  localparam int unsigned IRQ_COMPARE = 1;
  localparam int unsigned IRQ_TIMER   = 2;

  // Line-change events from the LCD timing logic
  typedef struct packed {
    logic vblank;
    logic compare;
  } lcd_evt_t;

  // Requests raised during one transaction
  typedef struct packed {
    logic timer;
    logic compare;
    logic vblank;
  } irq_req_t;

  // Result of the interrupt stage
  typedef struct packed {
    logic [IRQ_W-1:0] flags;
    logic             wake;
    logic             taken;
    logic [VEC_W-1:0] vector;
  } irq_res_t;

  // Timer period selected by timer_control[1:0]
  function automatic logic [TMR_CNT_W-1:0] timer_period(input logic [1:0] sel);
    logic [TMR_CNT_W-1:0] p;
    unique case (sel)
      2'd0:    p = 11'd1024;
      2'd1:    p = 11'd16;
      2'd2:    p = 11'd64;
      default: p = 11'd256;
    endcase
    return p;
  endfunction

endpackage

`default_nettype wire

>>> sv/vti_lcd.sv
// Scanline accumulator, line counter, compare flag and LCD mode decode.
// Combinational next-state logic; depends on vti_pkg.
`default_nettype none

module vti_lcd (
  input  wire logic [vti_pkg::CYC_W-1:0]      cyc,
  input  wire logic [vti_pkg::LINE_CNT_W-1:0] line_cyc_r,
  input  wire logic [vti_pkg::BYTE_W-1:0]     line_r,
  input  wire logic                           match_r,
  input  wire logic [vti_pkg::BYTE_W-1:0]     line_compare,
  input  wire logic                           compare_irq_en,
  output logic      [vti_pkg::LINE_CNT_W-1:0] line_cyc_nxt,
  output logic      [vti_pkg::BYTE_W-1:0]     line_nxt,
  output logic                                match_nxt,
  output logic      [1:0]                     mode,
  output vti_pkg::lcd_evt_t                   evt
);

  logic [vti_pkg::LINE_CNT_W:0] sum;
  logic                         wrap;

  always_comb begin
    sum          = {1'b0, line_cyc_r} + {{(vti_pkg::LINE_CNT_W+1-vti_pkg::CYC_W){1'b0}}, cyc};
    wrap         = (sum >= (vti_pkg::LINE_CNT_W+1)'(vti_pkg::LINE_CYCLES));
    line_nxt     = line_r;
    match_nxt    = match_r;
    evt          = '0;
    line_cyc_nxt = sum[vti_pkg::LINE_CNT_W-1:0];
    if (wrap) begin
      line_cyc_nxt = vti_pkg::LINE_CNT_W'(sum - (vti_pkg::LINE_CNT_W+1)'(vti_pkg::LINE_CYCLES));
      if (line_r >= vti_pkg::BYTE_W'(vti_pkg::LAST_LINE)) begin
        line_nxt = '0;
      end else begin
        line_nxt = line_r + 8'd1;
      end
      match_nxt   = (line_nxt == line_compare);
      evt.compare = compare_irq_en && match_nxt;
      evt.vblank  = (line_nxt == vti_pkg::BYTE_W'(vti_pkg::VBLANK_LINE));
    end

    if (line_nxt >= vti_pkg::BYTE_W'(vti_pkg::VBLANK_LINE)) begin
      mode = vti_pkg::MODE_VBLANK;
    end else if (line_cyc_nxt >= vti_pkg::LINE_CNT_W'(vti_pkg::HBLANK_START)) begin
      mode = vti_pkg::MODE_HBLANK;
    end else if (line_cyc_nxt >= vti_pkg::LINE_CNT_W'(vti_pkg::TRANSFER_START)) begin
      mode = vti_pkg::MODE_TRANSFER;
    end else begin
      mode = vti_pkg::MODE_SEARCH;
    end
  end

endmodule

`default_nettype wire

>>> sv/vti_timer.sv
// Free-running divider and programmable timer with modulo reload.
// Combinational next-state logic; depends on vti_pkg.
`default_nettype none

module vti_timer (
  input  wire logic [vti_pkg::CYC_W-1:0]     cyc,
  input  wire logic [vti_pkg::DIV_CNT_W-1:0] div_cyc_r,
  input  wire logic [vti_pkg::BYTE_W-1:0]    div_r,
  input  wire logic [vti_pkg::TMR_CNT_W-1:0] tmr_cyc_r,
  input  wire logic [vti_pkg::BYTE_W-1:0]    tmr_r,
  input  wire logic [vti_pkg::TCTRL_W-1:0]   timer_control,
  input  wire logic [vti_pkg::BYTE_W-1:0]    timer_modulo,
  output logic      [vti_pkg::DIV_CNT_W-1:0] div_cyc_nxt,
  output logic      [vti_pkg::BYTE_W-1:0]    div_nxt,
  output logic      [vti_pkg::TMR_CNT_W-1:0] tmr_cyc_nxt,
  output logic      [vti_pkg::BYTE_W-1:0]    tmr_nxt,
  output logic                               overflow
);

  logic [vti_pkg::DIV_CNT_W:0]   div_sum;
  logic [vti_pkg::TMR_CNT_W-1:0] tmr_sum;
  logic [vti_pkg::TMR_CNT_W-1:0] period;

  always_comb begin
    // Divider: one tick at most per transaction
    div_sum     = {1'b0, div_cyc_r} + {{(vti_pkg::DIV_CNT_W+1-vti_pkg::CYC_W){1'b0}}, cyc};
    div_cyc_nxt = div_sum[vti_pkg::DIV_CNT_W-1:0];
    div_nxt     = div_r;
    if (div_sum >= (vti_pkg::DIV_CNT_W+1)'(vti_pkg::DIV_CYCLES)) begin
      div_cyc_nxt = vti_pkg::DIV_CNT_W'(div_sum - (vti_pkg::DIV_CNT_W+1)'(vti_pkg::DIV_CYCLES));
      div_nxt     = div_r + 8'd1;
    end

    // Timer: hold while stopped, accumulator wraps at the selected period
    period      = vti_pkg::timer_period(timer_control[1:0]);
    tmr_sum     = tmr_cyc_r + {{(vti_pkg::TMR_CNT_W-vti_pkg::CYC_W){1'b0}}, cyc};
    tmr_cyc_nxt = tmr_cyc_r;
    tmr_nxt     = tmr_r;
    overflow    = 1'b0;
    if (timer_control[2]) begin
      tmr_cyc_nxt = tmr_sum;
      if (tmr_sum >= period) begin
        tmr_cyc_nxt = tmr_sum - period;
        if (tmr_r == 8'hFF) begin
          tmr_nxt  = timer_modulo;
          overflow = 1'b1;
        end else begin
          tmr_nxt = tmr_r + 8'd1;
        end
      end
    end
  end

endmodule

`default_nettype wire

>>> sv/vti_irq.sv
// Interrupt flag update, enable masking and lowest-source dispatch.
// Combinational; depends on vti_pkg.
`default_nettype none

module vti_irq (
  input  wire logic [vti_pkg::IRQ_W-1:0] flags_r,
  input  wire logic [vti_pkg::IRQ_W-1:0] irq_enable,
  input  wire vti_pkg::irq_req_t         req,
  input  wire logic                      ime,
  output vti_pkg::irq_res_t              res
);

  logic [vti_pkg::IRQ_W-1:0] raised;
  logic [vti_pkg::IRQ_W-1:0] flags_set;
  logic [vti_pkg::IRQ_W-1:0] pend;
  logic                      found;

  always_comb begin
    raised = '0;
    raised[vti_pkg::IRQ_VBLANK]  = req.vblank;
    raised[vti_pkg::IRQ_COMPARE] = req.compare;
    raised[vti_pkg::IRQ_TIMER]   = req.timer;

    // Masked requests still wake, but set no flag
    flags_set = flags_r | (raised & irq_enable);
    pend      = flags_set & irq_enable;
    found     = 1'b0;

    res.flags  = flags_set;
    res.wake   = |raised;
    res.taken  = 1'b0;
    res.vector = '0;
    for (int i = 0; i < vti_pkg::IRQ_W; i++) begin
      if (ime && !found && pend[i]) begin
        found        = 1'b1;
        res.taken    = 1'b1;
        res.flags[i] = 1'b0;
        res.vector   = {1'b1, 3'(i), 3'b000};
      end
    end
  end

endmodule

`default_nettype wire

>>> sv/video_timer_interrupt_unit.sv
// Top level of the video timer interrupt unit: handshakes, state and config registers.
// Instantiates vti_lcd, vti_timer and vti_irq; depends on vti_pkg.
`default_nettype none

// Each input transaction reports the machine cycles that elapsed since the last
// one and the CPU's master interrupt enable. The unit advances the scanline
// accumulator and line counter (0..153), recomputes the line-compare flag on
// each line change, raises vertical blank on entering line 144, ticks the
// divider and runs the programmable timer (period from
// timer_control[1:0], run bit timer_control[2], reload from timer_modulo on
// overflow). Requests are masked by interrupt_enable, and with the master
// enable set the lowest pending enabled source is taken: its vector comes out
// and its flag is cleared. At most one line step, one divider tick and one
// timer tick happen per transaction. The unit takes one transaction per clock
// while out_stall is low; each one passes through an input register and
// a result register before its result reaches the outputs. All state is read
// and written in the single stage between those two registers, which is what
// lets one transaction follow the next on consecutive clocks. The configuration
// port is always ready; write registers only while no transaction is in flight.
module video_timer_interrupt_unit (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  // input channel
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic [vti_pkg::CYC_W-1:0]       in_elapsed_cycles,
  input  wire logic                            in_master_enable,
  // result channel
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic      [vti_pkg::BYTE_W-1:0]      out_line_number,
  output logic      [1:0]                      out_video_mode,
  output logic                                 out_line_match,
  output logic      [vti_pkg::BYTE_W-1:0]      out_divider_value,
  output logic      [vti_pkg::BYTE_W-1:0]      out_timer_value,
  output logic      [vti_pkg::IRQ_W-1:0]       out_pending_flags,
  output logic                                 out_wake,
  output logic                                 out_dispatch,
  output logic      [vti_pkg::VEC_W-1:0]       out_vector_address,
  // configuration port
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [vti_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [vti_pkg::CFG_DATA_W-1:0]  cfg_data
);

  // Configuration registers
  logic [vti_pkg::BYTE_W-1:0]    line_compare_r;
  logic                          cmp_irq_en_r;
  logic [vti_pkg::TCTRL_W-1:0]   timer_control_r;
  logic [vti_pkg::BYTE_W-1:0]    timer_modulo_r;
  logic [vti_pkg::IRQ_W-1:0]     irq_enable_r;

  // Input register
  logic                          in_vld_r;
  logic [vti_pkg::CYC_W-1:0]     cyc_r;
  logic                          ime_r;

  // Architectural state
  logic [vti_pkg::LINE_CNT_W-1:0] line_cyc_r, line_cyc_nxt;
  logic [vti_pkg::BYTE_W-1:0]     line_r, line_nxt;
  logic                           match_r, match_nxt;
  logic [vti_pkg::DIV_CNT_W-1:0]  div_cyc_r, div_cyc_nxt;
  logic [vti_pkg::BYTE_W-1:0]     div_r, div_nxt;
  logic [vti_pkg::TMR_CNT_W-1:0]  tmr_cyc_r, tmr_cyc_nxt;
  logic [vti_pkg::BYTE_W-1:0]     tmr_r, tmr_nxt;
  logic [vti_pkg::IRQ_W-1:0]      flags_r;

  // Result register
  logic                           out_vld_r;
  logic [1:0]                     mode_r;
  logic                           wake_r;
  logic                           taken_r;
  logic [vti_pkg::VEC_W-1:0]      vector_r;

  logic [1:0]                     mode;
  logic                           tmr_ovf;
  vti_pkg::lcd_evt_t              lcd_evt;
  vti_pkg::irq_req_t              irq_req;
  vti_pkg::irq_res_t              irq_res;

  logic in_take;
  logic exec_go;

  // The execute stage fires when the result register is free or draining.
  assign exec_go  = in_vld_r && (!out_vld_r || !out_stall);
  assign in_stall = in_vld_r && !exec_go;
  assign in_take  = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  vti_lcd u_lcd (
    .cyc            (cyc_r),
    .line_cyc_r     (line_cyc_r),
    .line_r         (line_r),
    .match_r        (match_r),
    .line_compare   (line_compare_r),
    .compare_irq_en (cmp_irq_en_r),
    .line_cyc_nxt   (line_cyc_nxt),
    .line_nxt       (line_nxt),
    .match_nxt      (match_nxt),
    .mode           (mode),
    .evt            (lcd_evt)
  );

  vti_timer u_timer (
    .cyc           (cyc_r),
    .div_cyc_r     (div_cyc_r),
    .div_r         (div_r),
    .tmr_cyc_r     (tmr_cyc_r),
    .tmr_r         (tmr_r),
    .timer_control (timer_control_r),
    .timer_modulo  (timer_modulo_r),
    .div_cyc_nxt   (div_cyc_nxt),
    .div_nxt       (div_nxt),
    .tmr_cyc_nxt   (tmr_cyc_nxt),
    .tmr_nxt       (tmr_nxt),
    .overflow      (tmr_ovf)
  );

  always_comb begin
    irq_req.vblank  = lcd_evt.vblank;
    irq_req.compare = lcd_evt.compare;
    irq_req.timer   = tmr_ovf;
  end

  vti_irq u_irq (
    .flags_r    (flags_r),
    .irq_enable (irq_enable_r),
    .req        (irq_req),
    .ime        (ime_r),
    .res        (irq_res)
  );

  // Configuration writes; unknown indexes drop silently
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_compare_r  <= '0;
      cmp_irq_en_r    <= 1'b0;
      timer_control_r <= '0;
      timer_modulo_r  <= '0;
      irq_enable_r    <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        vti_pkg::CFG_LINE_COMPARE:   line_compare_r  <= cfg_data;
        vti_pkg::CFG_COMPARE_IRQ_EN: cmp_irq_en_r    <= cfg_data[0];
        vti_pkg::CFG_TIMER_CONTROL:  timer_control_r <= cfg_data[vti_pkg::TCTRL_W-1:0];
        vti_pkg::CFG_TIMER_MODULO:   timer_modulo_r  <= cfg_data;
        vti_pkg::CFG_IRQ_ENABLE:     irq_enable_r    <= cfg_data[vti_pkg::IRQ_W-1:0];
        default: ;
      endcase
    end
  end

  // Input register: capture a transaction, release it when execute fires
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_take) begin
      in_vld_r <= 1'b1;
    end else if (exec_go) begin
      in_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      cyc_r <= in_elapsed_cycles;
      ime_r <= in_master_enable;
    end
  end

  // State advances only when a transaction executes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_cyc_r <= '0;
      line_r     <= '0;
      match_r    <= 1'b0;
      div_cyc_r  <= '0;
      div_r      <= '0;
      tmr_cyc_r  <= '0;
      tmr_r      <= '0;
      flags_r    <= '0;
    end else if (exec_go) begin
      line_cyc_r <= line_cyc_nxt;
      line_r     <= line_nxt;
      match_r    <= match_nxt;
      div_cyc_r  <= div_cyc_nxt;
      div_r      <= div_nxt;
      tmr_cyc_r  <= tmr_cyc_nxt;
      tmr_r      <= tmr_nxt;
      flags_r    <= irq_res.flags;
    end
  end

  // Result register: hold while stalled
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (exec_go) begin
      out_vld_r <= 1'b1;
    end else if (!out_stall) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec_go) begin
      mode_r   <= mode;
      wake_r   <= irq_res.wake;
      taken_r  <= irq_res.taken;
      vector_r <= irq_res.vector;
    end
  end

  // Counter and flag outputs read the state registers, which change only
  // together with the result register.
  assign out_valid          = out_vld_r;
  assign out_line_number    = line_r;
  assign out_video_mode     = mode_r;
  assign out_line_match     = match_r;
  assign out_divider_value  = div_r;
  assign out_timer_value    = tmr_r;
  assign out_pending_flags  = flags_r;
  assign out_wake           = wake_r;
  assign out_dispatch       = taken_r;
  assign out_vector_address = vector_r;

  // Line counter never leaves 0..153
  a_line_range: assert property (@(posedge clk) disable iff (!rst_n)
    line_r <= vti_pkg::BYTE_W'(vti_pkg::LAST_LINE))
    else $error("line counter out of range");

  // Scanline accumulator stays below one line
  a_line_cyc_range: assert property (@(posedge clk) disable iff (!rst_n)
    line_cyc_r < vti_pkg::LINE_CNT_W'(vti_pkg::LINE_CYCLES))
    else $error("scanline accumulator out of range");

  // Serial and joypad flags are never raised here
  a_no_ext_flags: assert property (@(posedge clk) disable iff (!rst_n)
    flags_r[4:3] == 2'b00)
    else $error("unexpected serial or joypad flag");

  // A taken interrupt carries a vector, and only then
  a_vector_taken: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> (taken_r == (vector_r != '0)))
    else $error("vector and dispatch disagree");

  // Result is held while stalled
  a_exec_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_stall) |-> !exec_go)
    else $error("execute overran a stalled result");

endmodule

`default_nettype wire
